[design/stack_allocator_with_markers_defines.svh]
// Assertion macros shared by the stack allocator modules.
`ifndef STACK_ALLOCATOR_WITH_MARKERS_DEFINES_SVH
`define STACK_ALLOCATOR_WITH_MARKERS_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define SAWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stack allocator assertion failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define SAWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stack allocator assertion failed");

`endif

[design/sawm_pkg.sv]
// Types and constants for the stack allocator with markers.
package sawm_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int NEED_W     = DATA_W + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP   = 2'd2;

    localparam logic [DATA_W-1:0] RST_BASE = 32'd0;
    localparam logic [DATA_W-1:0] RST_SIZE = 32'd65536;
    localparam logic              RST_UP   = 1'b1;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [DATA_W-1:0] alloc_size;
        logic [2:0]        align_log2;
        logic [DATA_W-1:0] partner_used;
        logic [DATA_W-1:0] marker_top;
        logic [DATA_W-1:0] marker_count;
    } sawm_in_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] alloc_address;
        logic [DATA_W-1:0] top_address;
        logic [DATA_W-1:0] used_bytes;
        logic [DATA_W-1:0] alloc_count;
    } sawm_out_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } sawm_cmd_t;

endpackage

[design/sawm_ctrl.sv]
// Request sequencer: input capture, evaluate, commit and output valid.
`include "stack_allocator_with_markers_defines.svh"

module sawm_ctrl
    import sawm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output sawm_cmd_t cmd_o
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   slot_free;

    assign slot_free    = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign cmd_o.load   = s_valid && s_ready;
    assign cmd_o.eval   = (state_reg == ST_EVAL);
    assign cmd_o.commit = (state_reg == ST_COMMIT) && slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (slot_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cmd_o.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `SAWM_ASSERT_NEXT(a_accept_blocks, s_valid && s_ready, !s_ready)
    `SAWM_ASSERT_NEXT(a_commit_shows, cmd_o.commit, m_valid)
    `SAWM_ASSERT_NEXT(a_eval_to_commit, state_reg == ST_EVAL, state_reg == ST_COMMIT)

endmodule

[design/sawm_datapath.sv]
// Allocator state, configuration registers and request arithmetic.
`include "stack_allocator_with_markers_defines.svh"

module sawm_datapath
    import sawm_pkg::*;
#(
    parameter int ADDR_WIDTH     = 32,
    parameter int MAX_ALIGN_LOG2 = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sawm_cmd_t            cmd_i,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    input  sawm_in_t             s_data,
    output sawm_out_t            m_data
);

    localparam int AW    = ADDR_WIDTH;
    localparam int PAD_W = MAX_ALIGN_LOG2 + 1;
    localparam int CW    = (AW > DATA_W) ? AW : DATA_W;

    logic [DATA_W-1:0] base_reg, base_next;
    logic [DATA_W-1:0] size_reg, size_next;
    logic              up_reg, up_next;
    logic [AW-1:0]     top_reg;
    logic [DATA_W-1:0] used_reg;
    logic [DATA_W-1:0] cnt_reg;

    sawm_in_t          req_reg;
    logic [PAD_W-1:0]  pad_reg, pad_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [AW-1:0]     dist_reg, dist_next;
    logic [AW-1:0]     tms_reg, tms_next;
    sawm_out_t         out_reg;

    logic              cfg_hit;
    logic [AW-1:0]     start_cfg;
    logic [AW-1:0]     start_cur;
    logic [AW-1:0]     region_end;
    logic [2:0]        lg_sat;
    logic [PAD_W-1:0]  amask;
    logic [AW-1:0]     size_a;
    logic [AW-1:0]     mtop_a;
    logic              fit;
    logic              dist_ok;
    logic [AW-1:0]     addr_up;
    logic              nxt_ok;
    logic [AW-1:0]     nxt_addr;
    logic [AW-1:0]     nxt_top;
    logic [DATA_W-1:0] nxt_used;
    logic [DATA_W-1:0] nxt_cnt;
    logic              commit_q;
    logic              is_alloc;
    logic              is_clear;

    // configuration
    always_comb begin
        base_next = base_reg;
        size_next = size_reg;
        up_next   = up_reg;
        cfg_hit   = 1'b0;
        if (cfg_we) begin
            case (cfg_index)
                CFG_BASE: begin
                    base_next = cfg_wdata;
                    cfg_hit   = 1'b1;
                end
                CFG_SIZE: begin
                    size_next = cfg_wdata;
                    cfg_hit   = 1'b1;
                end
                CFG_UP: begin
                    up_next = cfg_wdata[0];
                    cfg_hit = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign start_cfg  = up_next ? AW'(base_next) : AW'(base_next) + AW'(size_next);
    assign region_end = AW'(base_reg) + AW'(size_reg);
    assign start_cur  = up_reg ? AW'(base_reg) : region_end;

    // evaluate step
    assign lg_sat = (32'(req_reg.align_log2) > MAX_ALIGN_LOG2) ? 3'(MAX_ALIGN_LOG2)
                                                                : req_reg.align_log2;
    assign amask  = (PAD_W'(1) << lg_sat) - PAD_W'(1);
    assign size_a = AW'(req_reg.alloc_size);
    assign mtop_a = AW'(req_reg.marker_top);

    always_comb begin
        tms_next  = top_reg - size_a;
        pad_next  = up_reg ? (PAD_W'(~top_reg + AW'(1)) & amask) : (PAD_W'(tms_next) & amask);
        need_next = NEED_W'(req_reg.partner_used) + NEED_W'(used_reg)
                  + NEED_W'(req_reg.alloc_size);
        dist_next = up_reg ? (mtop_a - AW'(base_reg)) : (region_end - mtop_a);
    end

    // commit step
    assign fit     = (need_reg + NEED_W'(pad_reg)) <= NEED_W'(size_reg);
    assign dist_ok = CW'(dist_reg) <= CW'(used_reg);
    assign addr_up = top_reg + AW'(pad_reg);

    always_comb begin
        nxt_ok   = 1'b0;
        nxt_addr = '0;
        nxt_top  = top_reg;
        nxt_used = used_reg;
        nxt_cnt  = cnt_reg;
        case (req_reg.req_type)
            REQ_ALLOC: begin
                if ((req_reg.alloc_size != '0) && fit) begin
                    nxt_ok   = 1'b1;
                    nxt_addr = up_reg ? addr_up : (tms_reg - AW'(pad_reg));
                    nxt_top  = up_reg ? (addr_up + size_a) : (tms_reg - AW'(pad_reg));
                    nxt_used = used_reg + DATA_W'(pad_reg) + req_reg.alloc_size;
                    nxt_cnt  = cnt_reg + DATA_W'(1);
                end
            end
            REQ_RELEASE: begin
                if (dist_ok) begin
                    nxt_ok   = 1'b1;
                    nxt_top  = mtop_a;
                    nxt_used = DATA_W'(dist_reg);
                    nxt_cnt  = req_reg.marker_count;
                end
            end
            REQ_CLEAR: begin
                nxt_ok   = 1'b1;
                nxt_top  = start_cur;
                nxt_used = '0;
                nxt_cnt  = '0;
            end
            default: begin
                nxt_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= RST_BASE;
            size_reg <= RST_SIZE;
            up_reg   <= RST_UP;
            top_reg  <= RST_UP ? AW'(RST_BASE) : AW'(RST_BASE) + AW'(RST_SIZE);
            used_reg <= '0;
            cnt_reg  <= '0;
        end else if (cfg_hit) begin
            base_reg <= base_next;
            size_reg <= size_next;
            up_reg   <= up_next;
            top_reg  <= start_cfg;
            used_reg <= '0;
            cnt_reg  <= '0;
        end else if (cmd_i.commit) begin
            top_reg  <= nxt_top;
            used_reg <= nxt_used;
            cnt_reg  <= nxt_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            req_reg <= s_data;
        end
        if (cmd_i.eval) begin
            pad_reg  <= pad_next;
            need_reg <= need_next;
            dist_reg <= dist_next;
            tms_reg  <= tms_next;
        end
        if (cmd_i.commit) begin
            out_reg.ok            <= nxt_ok;
            out_reg.alloc_address <= DATA_W'(nxt_addr);
            out_reg.top_address   <= DATA_W'(nxt_top);
            out_reg.used_bytes    <= nxt_used;
            out_reg.alloc_count   <= nxt_cnt;
        end
    end

    assign m_data = out_reg;

    assign commit_q = cmd_i.commit && !cfg_hit;
    assign is_alloc = (req_reg.req_type == REQ_ALLOC);
    assign is_clear = (req_reg.req_type == REQ_CLEAR);

    `SAWM_ASSERT_NEXT(a_reject_holds, commit_q && !nxt_ok, $stable(top_reg) && $stable(cnt_reg))
    `SAWM_ASSERT_NEXT(a_alloc_grows, commit_q && nxt_ok && is_alloc, used_reg != $past(used_reg))
    `SAWM_ASSERT_NEXT(a_clear_empties, commit_q && is_clear, (used_reg == '0) && (cnt_reg == '0))

endmodule

[design/stack_allocator_with_markers.sv]
// Top level of the bump-pointer stack allocator with markers.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  sawm_in_t  (one request)
//  m_       out        m_valid / m_ready  sawm_out_t (one result per request)
//  cfg_     in         cfg_we             cfg_index, cfg_wdata
//
// Each item passes through capture, evaluate (padding, fit sum, marker distance),
// and commit into the state and the output register. The next item is taken while a
// result waits in the output register; commit stalls until that register is free.
// Reset is synchronous on aresetn and loads base 0, size 65536, upward growth.
// A configuration write to base, size or direction restarts the allocator at the start of the region.
module stack_allocator_with_markers
    import sawm_pkg::*;
#(
    parameter int ADDR_WIDTH     = 32,
    parameter int MAX_ALIGN_LOG2 = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sawm_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sawm_out_t            m_data
);

    sawm_cmd_t cmd;

    sawm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd_o   (cmd)
    );

    sawm_datapath #(
        .ADDR_WIDTH     (ADDR_WIDTH),
        .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_i     (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data)
    );

endmodule
